// File: rtl/core/gpf_pkg.sv
// Package for the greedy paragraph filler: widths, character codes,
// register indexes, sequencer states and the result record.
// Depends on nothing; used by greedy_paragraph_filler_top.
package gpf_pkg;

	localparam int WORD_MAX = 61;
	localparam int CODE_W = 21;
	localparam int CFG_W = 10;
	localparam int LEN_W = $clog2(WORD_MAX + 1);
	localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
	// A line never gets past one column beyond the largest fill column.
	localparam int COL_W = CFG_W + 1;

	localparam logic [CODE_W-1:0] CODE_NEWLINE = CODE_W'(10);
	localparam logic [CODE_W-1:0] CODE_SPACE = CODE_W'(32);
	localparam logic [CODE_W-1:0] CODE_TAB = CODE_W'(9);
	localparam logic [CODE_W-1:0] CODE_PERIOD = CODE_W'(46);
	localparam logic [CODE_W-1:0] CODE_NONE = '0;

	typedef enum logic {
		REG_FILL_COLUMN = 1'b0,
		REG_START_COLUMN = 1'b1
	} gpf_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ERR = 6'b000010,
		ST_PREFIX = 6'b000100,
		ST_WORD = 6'b001000,
		ST_PERIOD = 6'b010000,
		ST_CLOSE = 6'b100000
	} gpf_state_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic last;
		logic done;
		logic err;
	} gpf_result_t;

endpackage

// File: rtl/core/gpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; the read register updates only when a read is enabled.
module gpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/greedy_paragraph_filler_top.sv
// Top level of the greedy paragraph filler: word gathering, line fitting
// and the result sequencer. Depends on gpf_pkg and gpf_ram.
//
// Channel  Direction  Handshake            Payload
// in       in         in_valid/in_ready    char_code, line_end, para_end
// out      out        out_valid/out_ready  out_code, run_last, para_done, fill_error
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word character is written to the word memory at accept. A separator that
// flushes a word of n characters sends any due prefix, the n characters, a
// trailing period space and a paragraph-closing newline where they apply; the
// single read port of the word memory gives one entry per cycle unless stalled.
// Reset (arst_n low) returns the filler to the start of a paragraph with a fill
// column of 72; the word memory is not cleared. A stalled output holds the
// sequencer, but word characters are still taken while a result waits.
module greedy_paragraph_filler_top
	import gpf_pkg::*;
(
	input logic clk,
	input logic arst_n,

	input logic in_valid,
	output logic in_ready,
	input logic [CODE_W-1:0] char_code,
	input logic line_end,
	input logic para_end,

	output logic out_valid,
	input logic out_ready,
	output logic [CODE_W-1:0] out_code,
	output logic run_last,
	output logic para_done,
	output logic fill_error,

	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	// Configuration registers.
	logic [CFG_W-1:0] fill_col_q;
	logic [CFG_W-1:0] start_col_q;

	// Paragraph state.
	logic [LEN_W-1:0] wl_q;
	logic [COL_W-1:0] line_col_q;
	logic fwp_q;
	logic ewp_q;

	// Sequencer state, latched when a flush begins.
	gpf_state_t state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic rdv_q;
	logic per_q;
	logic pe_q;
	logic pfx_nl_q;

	// Output register.
	logic out_valid_q;
	gpf_result_t out_q;

	logic accept;
	logic load_ok;
	logic is_sep;
	logic pe_in;
	logic fill_zero;
	logic [COL_W-1:0] col_base;
	logic [COL_W:0] fit_sum;
	logic fits;
	logic [COL_W:0] col_sum;
	logic flush_start;
	logic consume;
	logic more;
	logic issue_word;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic wr_en;
	logic [CODE_W-1:0] rd_data;
	logic emit;
	gpf_result_t res;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid & in_ready;
	assign load_ok = ~out_valid_q | out_ready;

	// A line end counts as a space; para_end matters only on a line end.
	assign is_sep = line_end | (char_code == CODE_SPACE) | (char_code == CODE_TAB);
	assign pe_in = line_end & para_end;
	assign fill_zero = (fill_col_q == '0);

	// Before the first word the column is the configured start column.
	assign col_base = fwp_q ? COL_W'(start_col_q) : line_col_q;
	assign fit_sum = (COL_W + 1)'(col_base) + (COL_W + 1)'(1) + (COL_W + 1)'(wl_q);
	assign fits = (fit_sum <= (COL_W + 1)'(fill_col_q));

	// Column after the flush: the word, its period space, and a separating
	// space when it stays on the current line after an earlier word.
	always_comb begin
		if (fits) begin
			col_sum = (COL_W + 1)'(col_base) + (COL_W + 1)'(!fwp_q)
				+ (COL_W + 1)'(wl_q) + (COL_W + 1)'(ewp_q);
		end else begin
			col_sum = (COL_W + 1)'(wl_q) + (COL_W + 1)'(ewp_q);
		end
	end

	// The first entry is read in the accept cycle, so the word streams out
	// right behind the prefix without a bubble.
	assign flush_start = accept & ~fill_zero & is_sep & (wl_q != '0);
	assign consume = (state_q == ST_WORD) & rdv_q & load_ok;
	assign more = (idx_q < len_q);
	assign issue_word = (state_q == ST_WORD) & more & (~rdv_q | consume);
	assign rd_en = flush_start | issue_word;
	assign rd_addr = flush_start ? '0 : idx_q[ADDR_W-1:0];
	assign wr_en = accept & ~fill_zero & ~is_sep & (wl_q < LEN_W'(WORD_MAX));

	gpf_ram #(
		.WIDTH(CODE_W),
		.DEPTH(WORD_MAX)
	) u_word_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wl_q[ADDR_W-1:0]),
		.wr_data(char_code),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Result selection per sequencer state.
	always_comb begin
		emit = 1'b0;
		res = '{code: CODE_NONE, last: 1'b0, done: 1'b0, err: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				emit = 1'b0;
			end
			ST_ERR: begin
				emit = load_ok;
				res = '{code: CODE_NONE, last: 1'b1, done: 1'b0, err: 1'b1};
			end
			ST_PREFIX: begin
				emit = load_ok;
				res.code = pfx_nl_q ? CODE_NEWLINE : CODE_SPACE;
			end
			ST_WORD: begin
				emit = consume;
				res.code = rd_data;
				res.last = ~more & ~per_q & ~pe_q;
			end
			ST_PERIOD: begin
				emit = load_ok;
				res.code = CODE_SPACE;
				res.last = ~pe_q;
			end
			ST_CLOSE: begin
				emit = load_ok;
				res = '{code: CODE_NEWLINE, last: 1'b1, done: 1'b1, err: 1'b0};
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_col_q <= CFG_W'(72);
			start_col_q <= '0;
			wl_q <= '0;
			line_col_q <= '0;
			fwp_q <= 1'b1;
			ewp_q <= 1'b0;
			state_q <= ST_IDLE;
			len_q <= '0;
			idx_q <= '0;
			rdv_q <= 1'b0;
			per_q <= 1'b0;
			pe_q <= 1'b0;
			pfx_nl_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid & cfg_ready) begin
				unique case (cfg_index)
					REG_FILL_COLUMN: fill_col_q <= cfg_data;
					REG_START_COLUMN: start_col_q <= cfg_data;
					default: ;
				endcase
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fill_zero) begin
							state_q <= ST_ERR;
						end else if (!is_sep) begin
							ewp_q <= (char_code == CODE_PERIOD);
							if (wl_q < LEN_W'(WORD_MAX)) begin
								wl_q <= wl_q + LEN_W'(1);
							end
						end else begin
							if (wl_q != '0) begin
								len_q <= wl_q;
								idx_q <= LEN_W'(1);
								rdv_q <= 1'b1;
								per_q <= ewp_q;
								pe_q <= pe_in;
								pfx_nl_q <= ~fits;
								line_col_q <= col_sum[COL_W-1:0];
								// The first word of a paragraph needs no prefix when it fits.
								state_q <= (fits & fwp_q) ? ST_WORD : ST_PREFIX;
							end else if (pe_in) begin
								state_q <= ST_CLOSE;
							end
							// A flushed word ends the wait for the first word;
							// a paragraph end starts it again.
							wl_q <= '0;
							if ((wl_q != '0) | pe_in) begin
								fwp_q <= pe_in;
							end
							if (pe_in) begin
								ewp_q <= 1'b0;
							end
						end
					end
				end
				ST_ERR: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PREFIX: begin
					if (load_ok) begin
						state_q <= ST_WORD;
					end
				end
				ST_WORD: begin
					if (issue_word) begin
						idx_q <= idx_q + LEN_W'(1);
					end
					rdv_q <= issue_word | (rdv_q & ~consume);
					if (consume & ~more) begin
						if (per_q) begin
							state_q <= ST_PERIOD;
						end else if (pe_q) begin
							state_q <= ST_CLOSE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PERIOD: begin
					if (load_ok) begin
						state_q <= pe_q ? ST_CLOSE : ST_IDLE;
					end
				end
				ST_CLOSE: begin
					if (load_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload of the output register needs no reset.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_code = out_q.code;
	assign run_last = out_q.last;
	assign para_done = out_q.done;
	assign fill_error = out_q.err;

endmodule
